[sv/rsd_pkg.sv]
// Types, codes and helper functions shared by the record stream deframer.
`default_nettype none

package rsd_pkg;

  // Record header layout
  localparam int unsigned MagicLen  = 8;
  localparam int unsigned LenBytes  = 8;
  localparam int unsigned CrcBytes  = 4;
  localparam int unsigned HdrLen    = MagicLen + LenBytes + CrcBytes;
  localparam int unsigned HdrCntW   = $clog2(HdrLen + 1);

  localparam logic [HdrCntW-1:0] HDR_LAST_CNT = HdrCntW'(HdrLen);
  localparam logic [HdrCntW-1:0] LEN_START    = HdrCntW'(MagicLen);
  localparam logic [HdrCntW-1:0] CRC_START    = HdrCntW'(MagicLen + LenBytes);

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Reset value of the maximum body length register
  localparam logic [63:0] MAX_SIZE_RESET = 64'h0000_0000_2000_0000;

  // Input word kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  // Result event codes
  localparam logic [1:0] EV_BODY  = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT_HDR = 3'd1;
  localparam logic [2:0] ERR_MAGIC     = 3'd2;
  localparam logic [2:0] ERR_CRC       = 3'd3;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
  localparam logic [2:0] ERR_SHORT_BDY = 3'd5;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_ERROR  = 2'd2
  } phase_t;

  // Expected magic byte at header position idx
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] m;
    case (idx)
      3'd0:    m = 8'hFC;
      3'd1:    m = 8'hAE;
      3'd2:    m = 8'h95;
      3'd3:    m = 8'h31;
      3'd4:    m = 8'hF0;
      3'd5:    m = 8'hD9;
      3'd6:    m = 8'hBD;
      3'd7:    m = 8'h20;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // One byte of the reflected CRC-32 update, bit by bit
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/record_stream_deframer.sv]
// Record stream deframer: header check, body pass-through and error reporting.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+--------------------
//  input   | in_kind, in_byte_value                        | in_valid / in_ready
//  result  | out_event_res, out_data_byte, out_last_byte,  | out_valid / out_ready
//          | out_error_code, out_record_length             |
//  config  | cfg_wr_data (max body length)                 | cfg_wr_en
//
// One word per cycle sustained while the result register is not stalled: a word
// is captured in the input register, then one pass of CRC byte update, header
// checks and body count sets the state and, for a word that yields a result,
// loads the result register, which drives out_valid.
// Reset (rst_n low, synchronous) clears the record state and sets the
// maximum body length to 2^29. A stalled result register holds the input
// register, which then holds in_ready low until the result is taken.
`default_nettype none

module record_stream_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_byte_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_res,
  output logic [7:0]       out_data_byte,
  output logic             out_last_byte,
  output logic [2:0]       out_error_code,
  output logic [63:0]      out_record_length,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data
);

  // Configuration register
  logic [63:0] max_size_r;

  // Input register
  logic       s1_valid_r;
  logic       s1_kind_r;
  logic [7:0] s1_byte_r;

  // Record state
  rsd_pkg::phase_t               phase_r, phase_nxt;
  logic [rsd_pkg::HdrCntW-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic                          magic_ok_r, magic_ok_nxt;
  logic [63:0]                   length_r, length_nxt;
  logic [31:0]                   crc_run_r, crc_run_nxt;
  logic [31:0]                   crc_exp_r, crc_exp_nxt;
  logic [63:0]                   remain_r, remain_nxt;

  // Result register
  logic        out_valid_r;
  logic [1:0]  out_event_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic [2:0]  out_err_r;
  logic [63:0] out_len_r;

  // Result of the current word
  logic        res_valid;
  logic [1:0]  res_event;
  logic [7:0]  res_data;
  logic        res_last;
  logic [2:0]  res_err;
  logic [63:0] res_len;

  logic        out_free;
  logic        s1_go;
  logic [63:0] remain_dec;

  // Handshake
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  // Configuration register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= rsd_pkg::MAX_SIZE_RESET;
    end else if (cfg_wr_en) begin
      max_size_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_byte_value;
    end
  end

  assign remain_dec = remain_r - 64'd1;

  // Next state and result for the word in the input register
  always_comb begin
    logic [rsd_pkg::HdrCntW-1:0] cnt_inc;
    logic                        hdr_done;

    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    magic_ok_nxt = magic_ok_r;
    length_nxt   = length_r;
    crc_run_nxt  = crc_run_r;
    crc_exp_nxt  = crc_exp_r;
    remain_nxt   = remain_r;

    res_valid = 1'b0;
    res_event = rsd_pkg::EV_BODY;
    res_data  = 8'd0;
    res_last  = 1'b0;
    res_err   = rsd_pkg::ERR_NONE;
    res_len   = 64'd0;

    cnt_inc  = hdr_cnt_r + 1'b1;
    hdr_done = (cnt_inc == rsd_pkg::HDR_LAST_CNT);

    if (s1_kind_r == rsd_pkg::KIND_EOS) begin
      // End of stream: report by phase, then start a fresh record
      case (phase_r)
        rsd_pkg::PH_HEADER: begin
          res_valid = 1'b1;
          if (hdr_cnt_r == '0) begin
            res_event = rsd_pkg::EV_END;
          end else begin
            res_event = rsd_pkg::EV_ERROR;
            res_err   = rsd_pkg::ERR_SHORT_HDR;
          end
        end
        rsd_pkg::PH_BODY: begin
          res_valid = 1'b1;
          res_event = rsd_pkg::EV_ERROR;
          res_err   = rsd_pkg::ERR_SHORT_BDY;
          res_len   = length_r;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
      phase_nxt    = rsd_pkg::PH_HEADER;
      hdr_cnt_nxt  = '0;
      magic_ok_nxt = 1'b1;
      length_nxt   = 64'd0;
      crc_run_nxt  = rsd_pkg::CRC_INIT;
      crc_exp_nxt  = 32'd0;
      remain_nxt   = 64'd0;
    end else begin
      case (phase_r)
        // Body byte: pass through, mark the last one
        rsd_pkg::PH_BODY: begin
          res_valid = 1'b1;
          res_event = rsd_pkg::EV_BODY;
          res_data  = s1_byte_r;
          res_last  = (remain_dec == 64'd0);
          res_len   = length_r;
          remain_nxt = remain_dec;
          if (remain_dec == 64'd0) begin
            phase_nxt    = rsd_pkg::PH_HEADER;
            hdr_cnt_nxt  = '0;
            magic_ok_nxt = 1'b1;
            length_nxt   = 64'd0;
            crc_run_nxt  = rsd_pkg::CRC_INIT;
            crc_exp_nxt  = 32'd0;
          end
        end
        // Header byte: magic compare, length and CRC assembly
        rsd_pkg::PH_HEADER: begin
          if (hdr_cnt_r < rsd_pkg::LEN_START) begin
            if (s1_byte_r != rsd_pkg::magic_byte(hdr_cnt_r[2:0])) begin
              magic_ok_nxt = 1'b0;
            end
          end else if (hdr_cnt_r < rsd_pkg::CRC_START) begin
            case (hdr_cnt_r[2:0])
              3'd0:    length_nxt[7:0]   = s1_byte_r;
              3'd1:    length_nxt[15:8]  = s1_byte_r;
              3'd2:    length_nxt[23:16] = s1_byte_r;
              3'd3:    length_nxt[31:24] = s1_byte_r;
              3'd4:    length_nxt[39:32] = s1_byte_r;
              3'd5:    length_nxt[47:40] = s1_byte_r;
              3'd6:    length_nxt[55:48] = s1_byte_r;
              default: length_nxt[63:56] = s1_byte_r;
            endcase
            crc_run_nxt = rsd_pkg::crc_byte(crc_run_r, s1_byte_r);
          end else begin
            case (hdr_cnt_r[1:0])
              2'd0:    crc_exp_nxt[7:0]   = s1_byte_r;
              2'd1:    crc_exp_nxt[15:8]  = s1_byte_r;
              2'd2:    crc_exp_nxt[23:16] = s1_byte_r;
              default: crc_exp_nxt[31:24] = s1_byte_r;
            endcase
          end
          hdr_cnt_nxt = cnt_inc;

          // Whole header in: checks in order magic, CRC, size, then an empty body
          if (hdr_done) begin
            if (!magic_ok_nxt) begin
              phase_nxt = rsd_pkg::PH_ERROR;
              res_valid = 1'b1;
              res_event = rsd_pkg::EV_ERROR;
              res_err   = rsd_pkg::ERR_MAGIC;
              res_len   = length_nxt;
            end else if ((crc_run_nxt ^ rsd_pkg::CRC_INIT) != crc_exp_nxt) begin
              phase_nxt = rsd_pkg::PH_ERROR;
              res_valid = 1'b1;
              res_event = rsd_pkg::EV_ERROR;
              res_err   = rsd_pkg::ERR_CRC;
              res_len   = length_nxt;
            end else if (length_nxt > max_size_r) begin
              phase_nxt = rsd_pkg::PH_ERROR;
              res_valid = 1'b1;
              res_event = rsd_pkg::EV_ERROR;
              res_err   = rsd_pkg::ERR_TOO_LARGE;
              res_len   = length_nxt;
            end else if (length_nxt == 64'd0) begin
              res_valid    = 1'b1;
              res_event    = rsd_pkg::EV_EMPTY;
              phase_nxt    = rsd_pkg::PH_HEADER;
              hdr_cnt_nxt  = '0;
              magic_ok_nxt = 1'b1;
              length_nxt   = 64'd0;
              crc_run_nxt  = rsd_pkg::CRC_INIT;
              crc_exp_nxt  = 32'd0;
              remain_nxt   = 64'd0;
            end else begin
              phase_nxt  = rsd_pkg::PH_BODY;
              remain_nxt = length_nxt;
            end
          end
        end
        // After an error every byte is dropped until end of stream
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // Record state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rsd_pkg::PH_HEADER;
      hdr_cnt_r  <= '0;
      magic_ok_r <= 1'b1;
      length_r   <= 64'd0;
      crc_run_r  <= rsd_pkg::CRC_INIT;
      crc_exp_r  <= 32'd0;
      remain_r   <= 64'd0;
    end else if (s1_go) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      magic_ok_r <= magic_ok_nxt;
      length_r   <= length_nxt;
      crc_run_r  <= crc_run_nxt;
      crc_exp_r  <= crc_exp_nxt;
      remain_r   <= remain_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_event_r <= res_event;
      out_data_r  <= res_data;
      out_last_r  <= res_last;
      out_err_r   <= res_err;
      out_len_r   <= res_len;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_event_r;
  assign out_data_byte     = out_data_r;
  assign out_last_byte     = out_last_r;
  assign out_error_code    = out_err_r;
  assign out_record_length = out_len_r;

`ifndef SYNTHESIS
  // A record in its body always has bytes left to come
  a_body_remain: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rsd_pkg::PH_BODY |-> remain_r != 64'd0)
    else $error("body phase with zero bytes remaining");

  // The header count never passes the header length while in the header
  a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rsd_pkg::PH_HEADER |-> hdr_cnt_r < rsd_pkg::HDR_LAST_CNT)
    else $error("header count out of range");

  // Error code only with an error word, data and last only with a body word
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r != rsd_pkg::EV_ERROR |-> out_err_r == rsd_pkg::ERR_NONE)
    else $error("error code on a non-error word");

  a_body_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r != rsd_pkg::EV_BODY |-> out_data_r == 8'd0 && !out_last_r)
    else $error("data or last set on a non-body word");

  // A last body byte returns the deframer to the start of a header
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && res_valid && res_last |=> phase_r == rsd_pkg::PH_HEADER && hdr_cnt_r == '0)
    else $error("record state not cleared after last body byte");
`endif

endmodule

`default_nettype wire
